// ===== rtl/lav_pkg.sv =====
// shared types, constants and arithmetic helpers of the look-at view matrix block
package lav_pkg;

    localparam int W         = 32;               // port word width
    localparam int FRAC      = 30;               // fraction bits of a unit axis
    localparam int WIDE_W    = 64;               // raw vector and product width
    localparam int DOT_W     = 66;               // sum of three products
    localparam int POS_W     = 6;                // bit position inside a wide word
    localparam int NM_W      = 30;               // scaled magnitude width
    localparam int SQ_W      = 62;               // sum of squares width
    localparam int RT_W      = 31;               // root width
    localparam int Q_W       = 31;               // quotient width
    localparam int NUM_W     = 61;               // dividend width
    localparam int SQRT_STEPS  = 32;
    localparam int SQRT_PER    = 2;
    localparam int SQRT_STAGES = SQRT_STEPS / SQRT_PER;
    localparam int DIV_STEPS   = 31;
    localparam int DIV_PER     = 2;
    localparam int DIV_STAGES  = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
    localparam int ROWS      = 3;
    localparam int ROW_W     = 2;
    localparam int GAP_W     = 2;

    localparam logic [ROW_W-1:0] ROW_SIDE = 2'd0;
    localparam logic [ROW_W-1:0] ROW_UP   = 2'd1;
    localparam logic [ROW_W-1:0] ROW_FWD  = 2'd2;

    typedef logic signed [W-1:0]      t_word;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [DOT_W-1:0]  t_dot;

    // words riding along with a vector being normalized
    typedef struct packed {
        t_word [2:0] eye;
        t_word [2:0] aux;
    } t_pay;

    typedef struct packed {
        logic [2:0]           neg;
        logic [2:0][NM_W-1:0] mag;
        logic                 zero;
        t_pay                 pay;
    } t_tag;

    typedef struct packed {
        logic [WIDE_W-1:0] x;
        logic [WIDE_W-1:0] res;
    } t_sq;

    typedef struct packed {
        logic [RT_W-1:0]       d;
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][Q_W-1:0]   q;
    } t_dv;

    // one digit of the square root, trial bit 4**k
    function automatic t_sq sqrt_step(t_sq st, int k);
        logic [WIDE_W-1:0] b;
        logic [WIDE_W-1:0] t;
        t_sq nx;
        b = WIDE_W'(1) << (2 * k);
        t = st.res + b;
        if (st.x >= t) begin
            nx.x   = st.x - t;
            nx.res = (st.res >> 1) + b;
        end else begin
            nx.x   = st.x;
            nx.res = st.res >> 1;
        end
        return nx;
    endfunction

    // one quotient bit of three restoring divisions sharing a divisor
    function automatic t_dv div_step(t_dv st, int i);
        logic [NUM_W-1:0] ds;
        t_dv nx;
        nx = st;
        ds = NUM_W'(st.d) << i;
        for (int l = 0; l < 3; l++) begin
            if (st.rem[l] >= ds) begin
                nx.rem[l]  = st.rem[l] - ds;
                nx.q[l][i] = 1'b1;
            end
        end
        return nx;
    endfunction

    // q4.60 down to q2.30, nearest with ties away from zero, clamped to +-1
    function automatic t_word round_q30(t_wide v);
        logic [WIDE_W-1:0] mag;
        logic [WIDE_W-1:0] m;
        mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        m   = (mag + (WIDE_W'(1) << (FRAC - 1))) >> FRAC;
        if (m > (WIDE_W'(1) << FRAC)) begin
            m = WIDE_W'(1) << FRAC;
        end
        return v[WIDE_W-1] ? -t_word'(m[W-1:0]) : t_word'(m[W-1:0]);
    endfunction

    // negated q18.46 dot down to q16.16, nearest, saturated
    function automatic t_word trans_q16(t_dot dot);
        logic [DOT_W-1:0] mag;
        logic [DOT_W-1:0] m;
        logic             pos;
        t_word            r;
        pos = !dot[DOT_W-1] && (dot != '0);
        mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
        m   = (mag + (DOT_W'(1) << (FRAC - 1))) >> FRAC;
        if (pos) begin
            if (m > (DOT_W'(1) << (W - 1))) begin
                r = {1'b1, {(W-1){1'b0}}};
            end else begin
                r = -t_word'(m[W-1:0]);
            end
        end else begin
            if (m > ((DOT_W'(1) << (W - 1)) - DOT_W'(1))) begin
                r = {1'b0, {(W-1){1'b1}}};
            end else begin
                r = t_word'(m[W-1:0]);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/look_at_view_matrix.sv =====
// top level of the look-at view matrix block: two normalizers, cross products, row output
//
// takes one camera setup (eye, target, up; signed q16.16) when start is high and busy is
// low, and later emits three words on consecutive cycles, each marked by o_strobe: the
// side row, the true up row and the forward row, each with three q2.30 axis components
// and a saturated q16.16 translation. the receiver cannot stall, so the word rate sets
// the pace: busy goes high after each accept so that setups arrive no faster than their
// words can leave, while up to about 28 setups are in flight in the pipeline. o_degenerate
// marks all three words of a setup whose forward or side vector had zero length; their
// axis and translation fields are then zero.
module look_at_view_matrix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lav_pkg::t_word       i_eye_x,
    input  lav_pkg::t_word       i_eye_y,
    input  lav_pkg::t_word       i_eye_z,
    input  lav_pkg::t_word       i_target_x,
    input  lav_pkg::t_word       i_target_y,
    input  lav_pkg::t_word       i_target_z,
    input  lav_pkg::t_word       i_upward_x,
    input  lav_pkg::t_word       i_upward_y,
    input  lav_pkg::t_word       i_upward_z,
    output logic                 o_strobe,
    output logic [lav_pkg::ROW_W-1:0] o_row_index,
    output lav_pkg::t_word       o_axis_x,
    output lav_pkg::t_word       o_axis_y,
    output lav_pkg::t_word       o_axis_z,
    output lav_pkg::t_word       o_translation,
    output logic                 o_last_row,
    output logic                 o_degenerate
);

    logic accept;

    // accept spacing: one setup per three output words
    logic [lav_pkg::GAP_W-1:0] r_gap;

    // input register
    logic                 r_in_vld;
    lav_pkg::t_word [2:0] r_in_eye;
    lav_pkg::t_word [2:0] r_in_tgt;
    lav_pkg::t_word [2:0] r_in_up;

    // forward normalizer
    lav_pkg::t_wide [2:0] c_fwd;
    lav_pkg::t_pay        c_pay1;
    logic                 f_vld;
    lav_pkg::t_word [2:0] f_axis;
    lav_pkg::t_pay        f_pay;

    // up x forward products
    logic                 r_s1_vld;
    lav_pkg::t_wide [5:0] r_s1_prod;
    lav_pkg::t_word [2:0] r_s1_eye;
    lav_pkg::t_word [2:0] r_s1_fwd;

    // side normalizer
    lav_pkg::t_wide [2:0] c_side;
    lav_pkg::t_pay        c_pay2;
    logic                 s_vld;
    logic                 s_zero;
    lav_pkg::t_word [2:0] s_axis;
    lav_pkg::t_pay        s_pay;

    // forward x side products
    logic                 r_u1_vld;
    logic                 r_u1_deg;
    lav_pkg::t_wide [5:0] r_u1_prod;
    lav_pkg::t_word [2:0] r_u1_side;
    lav_pkg::t_word [2:0] r_u1_fwd;
    lav_pkg::t_word [2:0] r_u1_eye;

    // true up, rounded and clamped; all three axes side by side
    logic                      r_u2_vld;
    logic                      r_u2_deg;
    lav_pkg::t_word [2:0][2:0] r_u2_axis;
    lav_pkg::t_word [2:0]      r_u2_eye;

    // axis * eye products
    logic                      r_u3_vld;
    logic                      r_u3_deg;
    lav_pkg::t_wide [2:0][2:0] r_u3_prod;
    lav_pkg::t_word [2:0][2:0] r_u3_axis;

    // dot products
    logic                      r_u4_vld;
    logic                      r_u4_deg;
    lav_pkg::t_dot  [2:0]      r_u4_dot;
    lav_pkg::t_word [2:0][2:0] r_u4_axis;

    // finished rows, held until the next setup arrives
    logic                      r_u5_vld;
    logic                      r_u5_deg;
    lav_pkg::t_word [2:0]      r_u5_trans;
    lav_pkg::t_word [2:0][2:0] r_u5_axis;

    // row sequencer and output word
    logic [lav_pkg::ROW_W-1:0] r_row;
    logic                      r_act;
    logic [lav_pkg::ROW_W-1:0] n_row;
    logic                      r_strobe;
    logic [lav_pkg::ROW_W-1:0] r_o_row;
    lav_pkg::t_word [2:0]      r_o_axis;
    lav_pkg::t_word            r_o_trans;
    logic                      r_o_deg;

    assign busy   = (r_gap != '0);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (accept) begin
            r_gap <= lav_pkg::GAP_W'(lav_pkg::ROWS - 1);
        end else if (r_gap != '0) begin
            r_gap <= r_gap - 1'b1;
        end
    end

    // valid bits of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_u1_vld <= 1'b0;
            r_u2_vld <= 1'b0;
            r_u3_vld <= 1'b0;
            r_u4_vld <= 1'b0;
            r_u5_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
            r_s1_vld <= f_vld;
            r_u1_vld <= s_vld;
            r_u2_vld <= r_u1_vld;
            r_u3_vld <= r_u2_vld;
            r_u4_vld <= r_u3_vld;
            r_u5_vld <= r_u4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_eye <= {i_eye_z, i_eye_y, i_eye_x};
            r_in_tgt <= {i_target_z, i_target_y, i_target_x};
            r_in_up  <= {i_upward_z, i_upward_y, i_upward_x};
        end
    end

    // raw forward is eye minus target, 33 bits of range
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            c_fwd[l] = lav_pkg::t_wide'(r_in_eye[l]) - lav_pkg::t_wide'(r_in_tgt[l]);
        end
        c_pay1.eye = r_in_eye;
        c_pay1.aux = r_in_up;
    end

    lav_norm u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_val   (c_fwd),
        .i_pay   (c_pay1),
        .o_vld   (f_vld),
        .o_zero  (),
        .o_comp  (f_axis),
        .o_pay   (f_pay)
    );

    // side = up x forward; a zero forward gives a zero side as well
    always_ff @(posedge i_clk) begin
        r_s1_prod[0] <= lav_pkg::t_wide'(f_pay.aux[1]) * lav_pkg::t_wide'(f_axis[2]);
        r_s1_prod[1] <= lav_pkg::t_wide'(f_pay.aux[2]) * lav_pkg::t_wide'(f_axis[1]);
        r_s1_prod[2] <= lav_pkg::t_wide'(f_pay.aux[2]) * lav_pkg::t_wide'(f_axis[0]);
        r_s1_prod[3] <= lav_pkg::t_wide'(f_pay.aux[0]) * lav_pkg::t_wide'(f_axis[2]);
        r_s1_prod[4] <= lav_pkg::t_wide'(f_pay.aux[0]) * lav_pkg::t_wide'(f_axis[1]);
        r_s1_prod[5] <= lav_pkg::t_wide'(f_pay.aux[1]) * lav_pkg::t_wide'(f_axis[0]);
        r_s1_eye     <= f_pay.eye;
        r_s1_fwd     <= f_axis;
    end

    always_comb begin
        c_side[0]  = r_s1_prod[0] - r_s1_prod[1];
        c_side[1]  = r_s1_prod[2] - r_s1_prod[3];
        c_side[2]  = r_s1_prod[4] - r_s1_prod[5];
        c_pay2.eye = r_s1_eye;
        c_pay2.aux = r_s1_fwd;
    end

    lav_norm u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s1_vld),
        .i_val   (c_side),
        .i_pay   (c_pay2),
        .o_vld   (s_vld),
        .o_zero  (s_zero),
        .o_comp  (s_axis),
        .o_pay   (s_pay)
    );

    // true up = forward x side, exact products first
    always_ff @(posedge i_clk) begin
        r_u1_prod[0] <= lav_pkg::t_wide'(s_pay.aux[1]) * lav_pkg::t_wide'(s_axis[2]);
        r_u1_prod[1] <= lav_pkg::t_wide'(s_pay.aux[2]) * lav_pkg::t_wide'(s_axis[1]);
        r_u1_prod[2] <= lav_pkg::t_wide'(s_pay.aux[2]) * lav_pkg::t_wide'(s_axis[0]);
        r_u1_prod[3] <= lav_pkg::t_wide'(s_pay.aux[0]) * lav_pkg::t_wide'(s_axis[2]);
        r_u1_prod[4] <= lav_pkg::t_wide'(s_pay.aux[0]) * lav_pkg::t_wide'(s_axis[1]);
        r_u1_prod[5] <= lav_pkg::t_wide'(s_pay.aux[1]) * lav_pkg::t_wide'(s_axis[0]);
        r_u1_side    <= s_axis;
        r_u1_fwd     <= s_pay.aux;
        r_u1_eye     <= s_pay.eye;
        r_u1_deg     <= s_zero;
    end

    // a degenerate setup zeroes the forward row too; side is already zero there
    always_ff @(posedge i_clk) begin
        r_u2_axis[lav_pkg::ROW_SIDE] <= r_u1_side;
        r_u2_axis[lav_pkg::ROW_FWD]  <= r_u1_deg ? '0 : r_u1_fwd;
        r_u2_axis[lav_pkg::ROW_UP][0] <= lav_pkg::round_q30(r_u1_prod[0] - r_u1_prod[1]);
        r_u2_axis[lav_pkg::ROW_UP][1] <= lav_pkg::round_q30(r_u1_prod[2] - r_u1_prod[3]);
        r_u2_axis[lav_pkg::ROW_UP][2] <= lav_pkg::round_q30(r_u1_prod[4] - r_u1_prod[5]);
        r_u2_eye <= r_u1_eye;
        r_u2_deg <= r_u1_deg;
    end

    // translation: -(axis . eye) per row
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int l = 0; l < 3; l++) begin
                r_u3_prod[r][l] <= lav_pkg::t_wide'(r_u2_axis[r][l])
                                 * lav_pkg::t_wide'(r_u2_eye[l]);
            end
        end
        r_u3_axis <= r_u2_axis;
        r_u3_deg  <= r_u2_deg;
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_u4_dot[r] <= lav_pkg::t_dot'(r_u3_prod[r][0]) + lav_pkg::t_dot'(r_u3_prod[r][1])
                         + lav_pkg::t_dot'(r_u3_prod[r][2]);
        end
        r_u4_axis <= r_u3_axis;
        r_u4_deg  <= r_u3_deg;
    end

    // loaded only with a live setup so the rows stay put while they go out
    always_ff @(posedge i_clk) begin
        if (r_u4_vld) begin
            for (int r = 0; r < 3; r++) begin
                r_u5_trans[r] <= lav_pkg::trans_q16(r_u4_dot[r]);
            end
            r_u5_axis <= r_u4_axis;
            r_u5_deg  <= r_u4_deg;
        end
    end

    // row sequencer: side on the first word, then up, then forward
    always_comb begin
        if (r_u5_vld) begin
            n_row = lav_pkg::ROW_SIDE;
        end else begin
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_row    <= lav_pkg::ROW_SIDE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_u5_vld || r_act;
            if (r_u5_vld || r_act) begin
                case (n_row)
                    lav_pkg::ROW_SIDE: begin
                        r_row <= lav_pkg::ROW_UP;
                        r_act <= 1'b1;
                    end
                    lav_pkg::ROW_UP: begin
                        r_row <= lav_pkg::ROW_FWD;
                        r_act <= 1'b1;
                    end
                    default: begin
                        r_row <= lav_pkg::ROW_SIDE;
                        r_act <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_row <= n_row;
        r_o_deg <= r_u5_deg;
        case (n_row)
            lav_pkg::ROW_SIDE: begin
                r_o_axis  <= r_u5_axis[lav_pkg::ROW_SIDE];
                r_o_trans <= r_u5_trans[lav_pkg::ROW_SIDE];
            end
            lav_pkg::ROW_UP: begin
                r_o_axis  <= r_u5_axis[lav_pkg::ROW_UP];
                r_o_trans <= r_u5_trans[lav_pkg::ROW_UP];
            end
            default: begin
                r_o_axis  <= r_u5_axis[lav_pkg::ROW_FWD];
                r_o_trans <= r_u5_trans[lav_pkg::ROW_FWD];
            end
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_row_index   = r_o_row;
    assign o_axis_x      = r_o_axis[0];
    assign o_axis_y      = r_o_axis[1];
    assign o_axis_z      = r_o_axis[2];
    assign o_translation = r_o_trans;
    assign o_last_row    = (r_o_row == lav_pkg::ROW_FWD);
    assign o_degenerate  = r_o_deg;

endmodule

// ===== rtl/lav_isqrt.sv =====
// pipelined integer square root, two digits per stage, tag carried alongside
module lav_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [lav_pkg::SQ_W-1:0] i_x,
    input  lav_pkg::t_tag            i_tag,
    output logic                     o_vld,
    output logic [lav_pkg::RT_W-1:0] o_root,
    output lav_pkg::t_tag            o_tag
);

    logic          c_vld [lav_pkg::SQRT_STAGES+1];
    lav_pkg::t_sq  c_st  [lav_pkg::SQRT_STAGES+1];
    lav_pkg::t_tag c_tag [lav_pkg::SQRT_STAGES+1];

    assign c_vld[0]    = i_vld;
    assign c_st[0].x   = lav_pkg::WIDE_W'(i_x);
    assign c_st[0].res = '0;
    assign c_tag[0]    = i_tag;

    for (genvar s = 0; s < lav_pkg::SQRT_STAGES; s++) begin : g_stg
        lav_pkg::t_sq  n_st;
        logic          r_vld;
        lav_pkg::t_sq  r_st;
        lav_pkg::t_tag r_tag;

        always_comb begin
            n_st = c_st[s];
            for (int j = 0; j < lav_pkg::SQRT_PER; j++) begin
                n_st = lav_pkg::sqrt_step(n_st,
                           lav_pkg::SQRT_STEPS - 1 - s * lav_pkg::SQRT_PER - j);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= c_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st  <= n_st;
            r_tag <= c_tag[s];
        end

        assign c_vld[s+1] = r_vld;
        assign c_st[s+1]  = r_st;
        assign c_tag[s+1] = r_tag;
    end

    assign o_vld  = c_vld[lav_pkg::SQRT_STAGES];
    assign o_root = c_st[lav_pkg::SQRT_STAGES].res[lav_pkg::RT_W-1:0];
    assign o_tag  = c_tag[lav_pkg::SQRT_STAGES];

endmodule

// ===== rtl/lav_div.sv =====
// pipelined three-lane restoring divider, rounds to nearest and restores signs
module lav_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [lav_pkg::RT_W-1:0]    i_root,
    input  lav_pkg::t_tag               i_tag,
    output logic                        o_vld,
    output logic                        o_zero,
    output lav_pkg::t_word [2:0]        o_comp,
    output lav_pkg::t_pay               o_pay
);

    logic          c_vld [lav_pkg::DIV_STAGES+1];
    lav_pkg::t_dv  c_st  [lav_pkg::DIV_STAGES+1];
    lav_pkg::t_tag c_tag [lav_pkg::DIV_STAGES+1];

    logic                 r_vld;
    logic                 r_zero;
    lav_pkg::t_word [2:0] r_comp;
    lav_pkg::t_pay        r_pay;

    // dividend is mag * 2^30 plus half the norm for rounding
    always_comb begin
        c_st[0].d = i_root;
        c_st[0].q = '0;
        for (int l = 0; l < 3; l++) begin
            c_st[0].rem[l] = (lav_pkg::NUM_W'(i_tag.mag[l]) << lav_pkg::FRAC)
                           + lav_pkg::NUM_W'(i_root >> 1);
        end
    end
    assign c_vld[0] = i_vld;
    assign c_tag[0] = i_tag;

    for (genvar s = 0; s < lav_pkg::DIV_STAGES; s++) begin : g_stg
        lav_pkg::t_dv  n_st;
        logic          r_svld;
        lav_pkg::t_dv  r_st;
        lav_pkg::t_tag r_tag;

        always_comb begin
            int idx;
            n_st = c_st[s];
            for (int j = 0; j < lav_pkg::DIV_PER; j++) begin
                idx = lav_pkg::DIV_STEPS - 1 - s * lav_pkg::DIV_PER - j;
                if (idx >= 0) begin
                    n_st = lav_pkg::div_step(n_st, idx);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_svld <= 1'b0;
            end else begin
                r_svld <= c_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st  <= n_st;
            r_tag <= c_tag[s];
        end

        assign c_vld[s+1] = r_svld;
        assign c_st[s+1]  = r_st;
        assign c_tag[s+1] = r_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= c_vld[lav_pkg::DIV_STAGES];
        end
    end

    // zero vector forces a zero axis
    always_ff @(posedge i_clk) begin
        r_zero <= c_tag[lav_pkg::DIV_STAGES].zero;
        r_pay  <= c_tag[lav_pkg::DIV_STAGES].pay;
        for (int l = 0; l < 3; l++) begin
            if (c_tag[lav_pkg::DIV_STAGES].zero) begin
                r_comp[l] <= '0;
            end else if (c_tag[lav_pkg::DIV_STAGES].neg[l]) begin
                r_comp[l] <= -lav_pkg::t_word'(c_st[lav_pkg::DIV_STAGES].q[l]);
            end else begin
                r_comp[l] <= lav_pkg::t_word'(c_st[lav_pkg::DIV_STAGES].q[l]);
            end
        end
    end

    assign o_vld  = r_vld;
    assign o_zero = r_zero;
    assign o_comp = r_comp;
    assign o_pay  = r_pay;

endmodule

// ===== rtl/lav_norm.sv =====
// vector normalizer: magnitude, range scaling, sum of squares, root, divide
module lav_norm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  lav_pkg::t_wide [2:0] i_val,
    input  lav_pkg::t_pay        i_pay,
    output logic                 o_vld,
    output logic                 o_zero,
    output lav_pkg::t_word [2:0] o_comp,
    output lav_pkg::t_pay        o_pay
);

    // stage 1: sign and magnitude
    logic                               r1_vld;
    logic [2:0]                         r1_neg;
    logic [2:0][lav_pkg::WIDE_W-1:0]    r1_mag;
    lav_pkg::t_pay                      r1_pay;
    // stage 2: leading one position
    logic                               r2_vld;
    logic [2:0]                         r2_neg;
    logic [2:0][lav_pkg::WIDE_W-1:0]    r2_mag;
    logic [lav_pkg::POS_W-1:0]          r2_pos;
    logic                               r2_zero;
    lav_pkg::t_pay                      r2_pay;
    // stage 3: scaled magnitudes
    logic                               r3_vld;
    lav_pkg::t_tag                      r3_tag;
    // stage 4: squares
    logic                               r4_vld;
    logic [2:0][2*lav_pkg::NM_W-1:0]    r4_sq;
    lav_pkg::t_tag                      r4_tag;
    // stage 5: sum of squares
    logic                               r5_vld;
    logic [lav_pkg::SQ_W-1:0]           r5_sum;
    lav_pkg::t_tag                      r5_tag;

    logic [lav_pkg::WIDE_W-1:0]         n_or;
    logic [lav_pkg::POS_W-1:0]          n_pos;
    logic [2:0][lav_pkg::NM_W-1:0]      n_scaled;

    logic                               s_vld;
    logic [lav_pkg::RT_W-1:0]           s_root;
    lav_pkg::t_tag                      s_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // highest set bit of the or equals that of the largest magnitude
    always_comb begin
        n_or  = r1_mag[0] | r1_mag[1] | r1_mag[2];
        n_pos = '0;
        for (int i = 0; i < lav_pkg::WIDE_W; i++) begin
            if (n_or[i]) begin
                n_pos = lav_pkg::POS_W'(i);
            end
        end
    end

    // bring the largest magnitude into [2^29, 2^30)
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r2_pos >= lav_pkg::POS_W'(lav_pkg::NM_W - 1)) begin
                n_scaled[l] = lav_pkg::NM_W'(r2_mag[l]
                              >> (r2_pos - lav_pkg::POS_W'(lav_pkg::NM_W - 1)));
            end else begin
                n_scaled[l] = lav_pkg::NM_W'(r2_mag[l]
                              << (lav_pkg::POS_W'(lav_pkg::NM_W - 1) - r2_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r1_neg[l] <= i_val[l][lav_pkg::WIDE_W-1];
            r1_mag[l] <= i_val[l][lav_pkg::WIDE_W-1] ? lav_pkg::WIDE_W'(-i_val[l])
                                                      : lav_pkg::WIDE_W'(i_val[l]);
        end
        r1_pay <= i_pay;

        r2_neg  <= r1_neg;
        r2_mag  <= r1_mag;
        r2_pos  <= n_pos;
        r2_zero <= (n_or == '0);
        r2_pay  <= r1_pay;

        r3_tag.neg  <= r2_neg;
        r3_tag.mag  <= n_scaled;
        r3_tag.zero <= r2_zero;
        r3_tag.pay  <= r2_pay;

        for (int l = 0; l < 3; l++) begin
            r4_sq[l] <= (2*lav_pkg::NM_W)'(r3_tag.mag[l])
                      * (2*lav_pkg::NM_W)'(r3_tag.mag[l]);
        end
        r4_tag <= r3_tag;

        r5_sum <= lav_pkg::SQ_W'(r4_sq[0]) + lav_pkg::SQ_W'(r4_sq[1])
                + lav_pkg::SQ_W'(r4_sq[2]);
        r5_tag <= r4_tag;
    end

    lav_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_x     (r5_sum),
        .i_tag   (r5_tag),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_tag   (s_tag)
    );

    lav_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_vld),
        .i_root  (s_root),
        .i_tag   (s_tag),
        .o_vld   (o_vld),
        .o_zero  (o_zero),
        .o_comp  (o_comp),
        .o_pay   (o_pay)
    );

endmodule

// ===== tb/look_at_view_matrix_check.sv =====
// checker: predicts the three view rows of each accepted camera setup and compares words
`timescale 1ns / 1ps

module look_at_view_matrix_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  lav_pkg::t_word       i_eye_x,
    input  lav_pkg::t_word       i_eye_y,
    input  lav_pkg::t_word       i_eye_z,
    input  lav_pkg::t_word       i_target_x,
    input  lav_pkg::t_word       i_target_y,
    input  lav_pkg::t_word       i_target_z,
    input  lav_pkg::t_word       i_upward_x,
    input  lav_pkg::t_word       i_upward_y,
    input  lav_pkg::t_word       i_upward_z,
    input  logic                 o_strobe,
    input  logic [lav_pkg::ROW_W-1:0] o_row_index,
    input  lav_pkg::t_word       o_axis_x,
    input  lav_pkg::t_word       o_axis_y,
    input  lav_pkg::t_word       o_axis_z,
    input  lav_pkg::t_word       o_translation,
    input  logic                 o_last_row,
    input  logic                 o_degenerate,
    output int                   o_fail_count,
    output int                   o_pending
);
    import lav_pkg::*;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [31:0]      ax, ay, az, tr;
        logic             last, degen;
    } t_row_word;

    t_row_word rows_due[$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = rows_due.size();

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint unsigned m;
        m = (absval(v) + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit vector in q2.30, returns 0 for a zero vector
    function automatic bit unit_q30(input longint v[3], output longint u[3]);
        longint unsigned m[3], top, sum, nrm, q;
        int rs, ls;
        top = 0; sum = 0; rs = 0; ls = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = absval(v[i]);
            if (m[i] > top) top = m[i];
        end
        if (top == 0) return 0;
        while (top >= (64'd1 << 30)) begin top >>= 1; rs++; end
        while (top < (64'd1 << 29)) begin top <<= 1; ls++; end
        for (int i = 0; i < 3; i++) begin
            m[i] = rs != 0 ? (m[i] >> rs) : (m[i] << ls);
            sum += m[i] * m[i];
        end
        nrm = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + (nrm >> 1)) / nrm;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > (64'sd1 << 30)) return 64'sd1 << 30;
        if (v < -(64'sd1 << 30)) return -(64'sd1 << 30);
        return v;
    endfunction

    task automatic predict_view(input longint eye[3], input longint tgt[3],
                                input longint upw[3]);
        longint fraw[3], sraw[3], ax[3][3], tr[3];
        logic signed [127:0] dot, t;
        bit ok;
        t_row_word w;
        for (int i = 0; i < 3; i++) fraw[i] = eye[i] - tgt[i];
        ok = unit_q30(fraw, ax[2]);
        if (ok) begin
            sraw[0] = upw[1] * ax[2][2] - upw[2] * ax[2][1];
            sraw[1] = upw[2] * ax[2][0] - upw[0] * ax[2][2];
            sraw[2] = upw[0] * ax[2][1] - upw[1] * ax[2][0];
            ok = unit_q30(sraw, ax[0]);
        end
        if (ok) begin
            ax[1][0] = clamp_unit(round_shift(ax[2][1]*ax[0][2] - ax[2][2]*ax[0][1], 30));
            ax[1][1] = clamp_unit(round_shift(ax[2][2]*ax[0][0] - ax[2][0]*ax[0][2], 30));
            ax[1][2] = clamp_unit(round_shift(ax[2][0]*ax[0][1] - ax[2][1]*ax[0][0], 30));
            for (int r = 0; r < 3; r++) begin
                // wide sum so the q18.46 dot never wraps
                dot = 128'(ax[r][0]) * 128'(eye[0]) + 128'(ax[r][1]) * 128'(eye[1])
                    + 128'(ax[r][2]) * 128'(eye[2]);
                dot = -dot;
                t = dot < 0 ? -((-dot + (128'sd1 <<< 29)) >>> 30)
                            : (dot + (128'sd1 <<< 29)) >>> 30;
                if (t > 128'sd2147483647) t = 128'sd2147483647;
                if (t < -128'sd2147483648) t = -128'sd2147483648;
                tr[r] = longint'(t);
            end
        end else begin
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) ax[r][i] = 0;
                tr[r] = 0;
            end
        end
        for (int r = 0; r < 3; r++) begin
            w.row   = ROW_W'(r);
            w.ax    = ax[r][0][31:0];
            w.ay    = ax[r][1][31:0];
            w.az    = ax[r][2][31:0];
            w.tr    = tr[r][31:0];
            w.last  = (r == 2);
            w.degen = !ok;
            rows_due.push_back(w);
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        longint e[3], t[3], u[3];
        t_row_word w;
        if (i_rst_n && start && !busy) begin
            e = '{longint'(i_eye_x), longint'(i_eye_y), longint'(i_eye_z)};
            t = '{longint'(i_target_x), longint'(i_target_y), longint'(i_target_z)};
            u = '{longint'(i_upward_x), longint'(i_upward_y), longint'(i_upward_z)};
            predict_view(e, t, u);
        end
        if (i_rst_n && o_strobe) begin
            if (rows_due.size() == 0) begin
                report("unexpected word", 32'(o_row_index), 32'hffffffff);
            end else begin
                w = rows_due.pop_front();
                if (o_row_index !== w.row)    report("row_index", 32'(o_row_index), 32'(w.row));
                if (o_axis_x !== w.ax)        report("axis_x", o_axis_x, w.ax);
                if (o_axis_y !== w.ay)        report("axis_y", o_axis_y, w.ay);
                if (o_axis_z !== w.az)        report("axis_z", o_axis_z, w.az);
                if (o_translation !== w.tr)   report("translation", o_translation, w.tr);
                if (o_last_row !== w.last)    report("last_row", 32'(o_last_row), 32'(w.last));
                if (o_degenerate !== w.degen) report("degenerate", 32'(o_degenerate), 32'(w.degen));
            end
        end
    end
endmodule

// ===== tb/look_at_view_matrix_test.sv =====
// testbench top: drives camera setups into the view matrix block and gives the verdict
`timescale 1ns / 1ps

module look_at_view_matrix_test;
    import lav_pkg::*;

    localparam int RANDOM_SETUPS = 310;
    localparam int STALL_LIMIT   = 2000;   // far above the pipeline latency
    localparam int DRAIN_CYCLES  = 120;

    logic   i_clk, i_rst_n, start, busy;
    t_word  i_eye_x, i_eye_y, i_eye_z, i_target_x, i_target_y, i_target_z;
    t_word  i_upward_x, i_upward_y, i_upward_z;
    logic   o_strobe, o_last_row, o_degenerate;
    logic [ROW_W-1:0] o_row_index;
    t_word  o_axis_x, o_axis_y, o_axis_z, o_translation;
    int     fail_count, pending;
    int     idle_cycles;
    int     gap_pct;

    look_at_view_matrix dut (.*);
    look_at_view_matrix_check checker_i (.*, .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: cycles with neither an accept nor a word
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // random coordinate: mostly moderate, sometimes extreme or tiny
    function automatic t_word any_coord();
        case ($urandom_range(0, 9))
            0: return t_word'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return t_word'($signed(32'($urandom_range(0, 8))) - 4);
            default: return t_word'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
        endcase
    endfunction

    // presents one setup and holds it until it is accepted; start drops only in idle gaps
    task automatic send_setup(input t_word e[3], input t_word t[3], input t_word u[3]);
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_eye_x    <= e[0]; i_eye_y    <= e[1]; i_eye_z    <= e[2];
        i_target_x <= t[0]; i_target_y <= t[1]; i_target_z <= t[2];
        i_upward_x <= u[0]; i_upward_y <= u[1]; i_upward_z <= u[2];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        t_word e[3], t[3], u[3];
        t_word one, mx, mn;
        int   pick;
        one = 32'sh00010000; mx = 32'sh7fffffff; mn = 32'sh80000000;
        idle_cycles = 0;
        gap_pct = 21;
        i_rst_n = 0; start = 0;
        {i_eye_x, i_eye_y, i_eye_z, i_target_x, i_target_y, i_target_z} = '0;
        {i_upward_x, i_upward_y, i_upward_z} = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: plain camera, field extremes, zero forward, zero and parallel up
        send_setup('{0, 0, 5*one}, '{0, 0, 0}, '{0, one, 0});
        send_setup('{one, 2*one, 3*one}, '{-one, 0, one}, '{0, 0, one});
        send_setup('{mx, mx, mx}, '{mn, mn, mn}, '{mx, mn, mx});
        send_setup('{mn, mn, mn}, '{mx, mx, mx}, '{mn, mx, mn});
        send_setup('{mx, mn, 0}, '{mn, mx, 0}, '{0, 0, mx});
        send_setup('{mn, 0, mx}, '{0, 0, 0}, '{mn, mn, mx});
        send_setup('{3*one, 4*one, 5*one}, '{3*one, 4*one, 5*one}, '{0, one, 0});
        send_setup('{mx, mn, mx}, '{mx, mn, mx}, '{one, one, one});
        send_setup('{one, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
        send_setup('{0, 2*one, 0}, '{0, 0, 0}, '{0, 7*one, 0});
        send_setup('{one, one, one}, '{0, 0, 0}, '{-2, -2, -2});
        send_setup('{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0});
        send_setup('{-1, -1, -1}, '{0, 0, 0}, '{1, 0, -1});
        send_setup('{32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f},
                   '{32'shaaaaaaaa, 32'sh55555555, 32'shf0f0f0f0},
                   '{32'sh33333333, 32'shcccccccc, 32'sh00ff00ff});
        send_setup('{mx, mx, mx}, '{0, 0, 0}, '{mx, mx, mn});

        for (int n = 0; n < RANDOM_SETUPS; n++) begin
            if (n == RANDOM_SETUPS / 3)     gap_pct = 81;
            if (n == 2 * RANDOM_SETUPS / 3) gap_pct = 0;
            for (int i = 0; i < 3; i++) begin
                e[i] = any_coord(); t[i] = any_coord(); u[i] = any_coord();
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) t = e;                         // eye on target
            else if (pick == 1) u = '{0, 0, 0};           // no up
            else if (pick == 2)                           // up along forward
                for (int i = 0; i < 3; i++) u[i] = t_word'(e[i] - t[i]);
            send_setup(e, t, u);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
